@@ hdl/bilinear_map_lookup_u8_unit_assert.svh @@
// Assertion macros for the bilinear map lookup unit.
`ifndef BILINEAR_MAP_LOOKUP_U8_UNIT_ASSERT_SVH
`define BILINEAR_MAP_LOOKUP_U8_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BML_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BML_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BML_ASSERT_IMP(label, ante, cons)
`define BML_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/bml_pkg.sv @@
// Shared constants and types for the bilinear map lookup unit.
`timescale 1ns / 1ps
package bml_pkg;
    localparam int MAX_X_POINTS_DEF = 16;
    localparam int MAX_Y_POINTS_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CFG_BITS         = 5;

    typedef enum logic [1:0] {
        OP_WR_X  = 2'd0,
        OP_WR_Y  = 2'd1,
        OP_WR_CELL = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    localparam logic [0:0] REG_X_COUNT = 1'b0;
    localparam logic [0:0] REG_Y_COUNT = 1'b1;
endpackage

@@ hdl/bml_divider.sv @@
// Restoring divider: quotient = (off << FRAC_BITS) / wid, one bit per cycle.
`timescale 1ns / 1ps
module bml_divider #(
    parameter int COORD_BITS = bml_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bml_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS:0]   off,
    input  logic [COORD_BITS:0]   wid,
    output logic                  done,
    output logic [FRAC_BITS-1:0]  quot
);
    localparam int CW = $clog2(FRAC_BITS + 1);
    logic [COORD_BITS+1:0] rem_reg, rem_next, trial;
    logic [COORD_BITS:0]   wid_reg;
    logic [FRAC_BITS-1:0]  quot_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    assign rem_next = {rem_reg[COORD_BITS:0], 1'b0};
    assign trial    = rem_next - {1'b0, wid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(FRAC_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    // pulses the cycle after the last quotient bit is shifted in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, off};
            wid_reg  <= wid;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[COORD_BITS+1])
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

@@ hdl/bilinear_map_lookup_u8_unit.sv @@
// Top level of the bilinear calibration map lookup unit.
`timescale 1ns / 1ps
// Bilinear map lookup: X/Y breakpoint axes and an 8-bit cell grid live in
// synchronous memories and are loaded by write words (operation 0/1/2).
// A lookup word (operation 3) scans each axis one breakpoint per cycle to
// find its segment, X then Y, divides the offset by the segment width in a
// shared bit-serial divider (skipped when the coordinate clamps), reads the
// four neighbor cells one per cycle from the cell memory, blends both rows
// along X together, then along Y. The unit is ready for the next word in
// the same cycle that out_valid rises. One word is in flight at a time; the
// result sits in an output register so the next word may be accepted while
// it waits.
module bilinear_map_lookup_u8_unit #(
    parameter int MAX_X_POINTS = bml_pkg::MAX_X_POINTS_DEF,
    parameter int MAX_Y_POINTS = bml_pkg::MAX_Y_POINTS_DEF,
    parameter int COORD_BITS   = bml_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS    = bml_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [3:0]            row,
    input  logic [3:0]            column,
    input  logic signed [15:0]    write_value,
    input  logic signed [15:0]    x_coord,
    input  logic signed [15:0]    y_coord,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            map_value,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [4:0]            cfg_data
);
`include "bilinear_map_lookup_u8_unit_assert.svh"
    localparam int XW = $clog2(MAX_X_POINTS);
    localparam int YW = $clog2(MAX_Y_POINTS);
    localparam int NW = (XW > YW ? XW : YW) + 1;
    localparam int CELLS = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int AW = XW + YW;
    localparam int CB = COORD_BITS;
    localparam int PW = 8 + 2 * FRAC_BITS + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DIVX, S_DIVY, S_RD0, S_RD1, S_RD2, S_RD3, S_WAIT,
        S_BLX, S_BLY, S_OUT
    } state_t;

    // memories
    logic signed [CB-1:0] xbp_mem [MAX_X_POINTS];
    logic signed [CB-1:0] ybp_mem [MAX_Y_POINTS];
    logic [7:0]           cell_mem [CELLS];
    logic signed [CB-1:0] bp_rd_reg;
    logic [7:0]           cell_rd_reg;

    state_t               state_reg;
    logic [4:0]           xcnt_reg, ycnt_reg;
    logic                 axis_reg;      // 0 scanning X, 1 scanning Y
    logic [NW-1:0]        k_reg;         // address being read
    logic                 rd_pend_reg;   // read data valid in bp_rd_reg
    logic signed [CB-1:0] prev_reg;      // breakpoint before the one in bp_rd_reg
    logic                 found_reg;     // segment already seen on this axis
    logic                 below_reg;     // coordinate below bp[0]
    logic [NW-1:0]        seg_reg;       // segment index found so far
    logic signed [CB-1:0] xc_reg, yc_reg;
    logic [NW-1:0]        ix_reg, iy_reg;
    logic [CB:0]          off_reg, wid_reg;
    logic                 fx_reg, fy_reg;    // fraction nonzero path
    logic [FRAC_BITS-1:0] tx_reg, ty_reg;
    logic [7:0]           c_reg [4];
    logic signed [PW-1:0] r0_reg, r1_reg;
    logic [7:0]           res_reg;
    logic                 out_valid_reg;

    logic [NW-1:0] nx, ny, n_cur;
    always_comb
    begin
        nx = (xcnt_reg == 5'd0) ? NW'(1) :
             ((32'(xcnt_reg) > MAX_X_POINTS) ? NW'(MAX_X_POINTS) : NW'(xcnt_reg));
        ny = (ycnt_reg == 5'd0) ? NW'(1) :
             ((32'(ycnt_reg) > MAX_Y_POINTS) ? NW'(MAX_Y_POINTS) : NW'(ycnt_reg));
        n_cur = axis_reg ? ny : nx;
    end

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xcnt_reg <= 5'd16;
            ycnt_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bml_pkg::REG_X_COUNT: xcnt_reg <= cfg_data;
                bml_pkg::REG_Y_COUNT: ycnt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the output register parts the result from the input side
    logic in_fire, out_fire, out_load;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // memory writes and reads
    logic [XW-1:0] cx_a, cx_b;
    logic [YW-1:0] cy_a, cy_b;
    logic [AW-1:0] cell_addr;
    logic          cell_rd;
    logic          dv_start;
    logic          dv_done;
    logic [FRAC_BITS-1:0] dv_q;

    always_comb
    begin
        cx_a = ix_reg[XW-1:0];
        cy_a = iy_reg[YW-1:0];
        cx_b = (ix_reg + 1'b1 < nx) ? XW'(ix_reg + 1'b1) : ix_reg[XW-1:0];
        cy_b = (iy_reg + 1'b1 < ny) ? YW'(iy_reg + 1'b1) : iy_reg[YW-1:0];
        cell_rd = 1'b1;
        case (state_reg)
            S_RD0:   cell_addr = {cy_a, cx_a};
            S_RD1:   cell_addr = {cy_a, cx_b};
            S_RD2:   cell_addr = {cy_b, cx_a};
            S_RD3:   cell_addr = {cy_b, cx_b};
            default:
            begin
                cell_addr = {cy_a, cx_a};
                cell_rd   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && operation == bml_pkg::OP_WR_X && 32'(column) < MAX_X_POINTS)
            xbp_mem[XW'(column)] <= CB'(write_value);
        if (in_fire && operation == bml_pkg::OP_WR_Y && 32'(row) < MAX_Y_POINTS)
            ybp_mem[YW'(row)] <= CB'(write_value);
        if (in_fire && operation == bml_pkg::OP_WR_CELL && 32'(row) < MAX_Y_POINTS
            && 32'(column) < MAX_X_POINTS)
            cell_mem[{YW'(row), XW'(column)}] <= write_value[7:0];
        if (axis_reg)
            bp_rd_reg <= ybp_mem[YW'(k_reg)];
        else
            bp_rd_reg <= xbp_mem[XW'(k_reg)];
        if (cell_rd)
            cell_rd_reg <= cell_mem[cell_addr];
    end

    // divider kicked on the first cycle of S_DIVX / S_DIVY when a fraction is needed
    logic div_go_reg;
    logic div_kick;
    assign div_kick = div_go_reg && ((state_reg == S_DIVX && fx_reg)
        || (state_reg == S_DIVY && fy_reg));
    assign dv_start = div_kick;

    bml_divider #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .off   (off_reg),
        .wid   (wid_reg),
        .done  (dv_done),
        .quot  (dv_q)
    );

    // scan comparisons: bp_rd_reg = bp[k-1] when rd_pend
    logic signed [CB-1:0] coord_cur;
    logic [NW-1:0]        kd;   // index of data in bp_rd_reg
    logic                 last_k;
    logic                 hit_seg, clamp_lo, clamp_hi, scan_end;
    logic [NW-1:0]        idx_pick;
    assign coord_cur = axis_reg ? yc_reg : xc_reg;
    assign kd        = k_reg - 1'b1;
    assign last_k    = (kd == n_cur - 1'b1);
    assign scan_end  = (state_reg == S_SCAN) && rd_pend_reg && last_k;
    // first k with bp[k] <= coord < bp[k+1]
    assign hit_seg   = rd_pend_reg && (kd != '0) && !found_reg
        && (prev_reg <= coord_cur) && (coord_cur < bp_rd_reg);
    // at or above the last breakpoint wins over below the first
    assign clamp_hi  = !(coord_cur < bp_rd_reg);
    assign clamp_lo  = (kd == '0) ? (coord_cur < bp_rd_reg) : below_reg;
    assign idx_pick  = clamp_hi ? n_cur - 1'b1 :
                       clamp_lo ? '0 :
                       hit_seg  ? kd - 1'b1 : seg_reg;

    // blend
    logic signed [PW-1:0] bl_lo, bl_hi, bl_res;
    logic [FRAC_BITS-1:0] bl_t;
    logic signed [PW-1:0] bl_d;
    always_comb
    begin
        if (state_reg == S_BLY)
        begin
            bl_lo = r0_reg;
            bl_hi = r1_reg;
            bl_t  = ty_reg;
        end
        else
        begin
            bl_lo = PW'($signed({1'b0, c_reg[0]}));
            bl_hi = PW'($signed({1'b0, c_reg[1]}));
            bl_t  = tx_reg;
        end
        bl_d   = bl_hi - bl_lo;
        bl_res = (bl_lo <<< FRAC_BITS) + PW'(bl_d * $signed({1'b0, bl_t}));
    end
    logic signed [PW-1:0] r1x;
    assign r1x = (PW'($signed({1'b0, c_reg[2]})) <<< FRAC_BITS)
        + PW'((PW'($signed({1'b0, c_reg[3]})) - PW'($signed({1'b0, c_reg[2]})))
        * $signed({1'b0, tx_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            axis_reg      <= 1'b0;
            k_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
            div_go_reg <= scan_end;
            unique case (state_reg)
                S_IDLE:
                    if (in_fire && operation == bml_pkg::OP_LOOKUP)
                    begin
                        xc_reg      <= CB'(x_coord);
                        yc_reg      <= CB'(y_coord);
                        axis_reg    <= 1'b0;
                        k_reg       <= '0;
                        rd_pend_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        fx_reg      <= 1'b0;
                        fy_reg      <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                S_SCAN:
                begin
                    // issue read of k_reg; compare data for k_reg-1
                    if (rd_pend_reg)
                    begin
                        prev_reg <= bp_rd_reg;
                        if (kd == '0)
                            below_reg <= coord_cur < bp_rd_reg;
                        if (hit_seg)
                        begin
                            seg_reg <= kd - 1'b1;
                            off_reg <= {coord_cur[CB-1], coord_cur}
                                - {prev_reg[CB-1], prev_reg};
                            wid_reg <= {bp_rd_reg[CB-1], bp_rd_reg}
                                - {prev_reg[CB-1], prev_reg};
                        end
                    end
                    if (rd_pend_reg && last_k)
                    begin
                        if (axis_reg)
                        begin
                            iy_reg <= idx_pick;
                            fy_reg <= !clamp_hi && !clamp_lo;
                        end
                        else
                        begin
                            ix_reg <= idx_pick;
                            fx_reg <= !clamp_hi && !clamp_lo;
                        end
                        k_reg       <= '0;
                        rd_pend_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        state_reg   <= axis_reg ? S_DIVY : S_DIVX;
                    end
                    else
                    begin
                        k_reg       <= k_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                        found_reg   <= found_reg || hit_seg;
                    end
                end
                S_DIVX:
                begin
                    if (!fx_reg)
                    begin
                        tx_reg    <= '0;
                        axis_reg  <= 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else if (dv_done)
                    begin
                        tx_reg    <= dv_q;
                        axis_reg  <= 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_DIVY:
                begin
                    if (!fy_reg)
                    begin
                        ty_reg    <= '0;
                        state_reg <= S_RD0;
                    end
                    else if (dv_done)
                    begin
                        ty_reg    <= dv_q;
                        state_reg <= S_RD0;
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    c_reg[0]  <= cell_rd_reg;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    c_reg[1]  <= cell_rd_reg;
                    state_reg <= S_RD3;
                end
                S_RD3:
                begin
                    c_reg[2]  <= cell_rd_reg;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    c_reg[3]  <= cell_rd_reg;
                    state_reg <= S_BLX;
                end
                S_BLX:
                begin
                    r0_reg    <= bl_res;
                    r1_reg    <= r1x;
                    state_reg <= S_BLY;
                end
                S_BLY:
                begin
                    r0_reg    <= bl_res;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_load)
                    begin
                        if (r0_reg < 0)
                            res_reg <= 8'd0;
                        else if ((r0_reg >>> (2 * FRAC_BITS)) > 255)
                            res_reg <= 8'd255;
                        else
                            res_reg <= r0_reg[2*FRAC_BITS +: 8];
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign map_value = res_reg;

    `BML_ASSERT_IMP(a_no_accept_busy, state_reg != S_IDLE, !in_ready)
    `BML_ASSERT_NEXT(a_lookup_starts, in_fire && operation == bml_pkg::OP_LOOKUP,
                     state_reg == S_SCAN)
    `BML_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg)
endmodule
